// ===== rtl/ssd_pkg.sv =====
// Shared constants, types and glyph tables for the seven-segment frame builder.
// Depends on nothing; every other file in this block uses it.
package ssd_pkg;

  localparam int DIGIT_COUNT = 8;
  localparam int VALUE_W     = 32;
  localparam int SEL_W       = 8;
  localparam int SEG_W       = 8;
  localparam int CHAR_W      = 8;
  localparam int POS_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int SYMBOL_COUNT = 28;
  localparam int PROD_W      = 2 * VALUE_W;
  localparam int RECIP_SHIFT = 35;

  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam logic [SEG_W-1:0]   MINUS_CODE = 8'hBF;
  localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(DIGIT_COUNT - 1);

  localparam logic [SEG_W-1:0] GLYPH_CODE [SYMBOL_COUNT] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90,
    8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'h82, 8'h89, 8'hF9, 8'hE1,
    8'hC7, 8'hC0, 8'h8C, 8'h92, 8'hC1, 8'h7F, 8'hFF, 8'hBF
  };

  localparam logic [CHAR_W-1:0] GLYPH_CHAR [SYMBOL_COUNT] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4C, 8'h4F, 8'h50, 8'h53, 8'h55, 8'h2E, 8'h20, 8'h2D
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIGIT,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic             found;
    logic [SEG_W-1:0] code;
  } glyph_t;

  function automatic glyph_t char_lookup(input logic [CHAR_W-1:0] ch);
    glyph_t res;
    res.found = 1'b0;
    res.code  = '1;
    for (int i = SYMBOL_COUNT - 1; i >= 0; i--) begin
      if (GLYPH_CHAR[i] == ch) begin
        res.found = 1'b1;
        res.code  = GLYPH_CODE[i];
      end
    end
    return res;
  endfunction

  function automatic logic [SEL_W-1:0] select_for(input logic [POS_W-1:0] pos);
    return SEL_W'(1) << (LAST_POS - pos);
  endfunction

endpackage

// ===== rtl/ssd_if.sv =====
// Valid/ready channel interfaces for the input items and the output frames.
// Depends on ssd_pkg for field widths.
interface ssd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic signed [ssd_pkg::VALUE_W-1:0]  value;

  modport source (output valid, operation, value, input ready);
  modport sink   (input valid, operation, value, output ready);
endinterface

interface ssd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssd_pkg::SEL_W-1:0]    digit_select;
  logic [ssd_pkg::SEG_W-1:0]    segments;
  logic                         last_frame;

  modport source (output valid, digit_select, segments, last_frame, input ready);
  modport sink   (input valid, digit_select, segments, last_frame, output ready);
endinterface

// ===== rtl/seven_segment_digit_frame_builder_top.sv =====
// Top level of the seven-segment frame builder: sequencer, output register and dot mask.
// Depends on ssd_pkg, ssd_if and ssd_div10.

// The block takes one item at a time; in_ch.ready is high only while it is idle.
// A character item is looked up combinationally while idle; its single frame then
// waits in the output register until transferred. A number item runs the shared
// divide-by-ten unit once per digit: the reciprocal multiply in ST_MUL, the
// remainder and segment code in ST_DIGIT, then the frame transfer in ST_SEND.
// A negative value with fewer than eight digits adds a minus frame after its
// digits. Zero and unknown characters produce no frames; the block stays idle.
module seven_segment_digit_frame_builder_top (
  input  logic                     clk,
  input  logic                     rst_n,
  ssd_in_if.sink                   in_ch,
  ssd_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [ssd_pkg::SEG_W-1:0] cfg_wdata
);
  import ssd_pkg::*;

  state_t             state_r, state_nxt;
  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SEL_W-1:0]   sel_r, sel_nxt;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic               last_r, last_nxt;
  logic [SEG_W-1:0]   dot_mask_r;

  logic               div_start;
  logic [VALUE_W-1:0] quotient;
  logic [3:0]         remainder;
  logic [VALUE_W-1:0] raw;
  glyph_t             glyph;
  logic [SEG_W-1:0]   digit_seg;

  ssd_div10 u_div10 (
    .clk       (clk),
    .start     (div_start),
    .dividend  (mag_r),
    .quotient  (quotient),
    .remainder (remainder)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_mask_r <= '0;
    end else if (cfg_we) begin
      dot_mask_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    pos_r  <= pos_nxt;
    sel_r  <= sel_nxt;
    seg_r  <= seg_nxt;
    last_r <= last_nxt;
  end

  assign raw   = VALUE_W'(in_ch.value);
  assign glyph = char_lookup(raw[CHAR_W-1:0]);

  always_comb begin
    digit_seg = GLYPH_CODE[{1'b0, remainder}];
    if (dot_mask_r[pos_r]) begin
      digit_seg[SEG_W-1] = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    sel_nxt   = sel_r;
    seg_nxt   = seg_r;
    last_nxt  = last_r;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation) begin
            sel_nxt  = select_for('0);
            seg_nxt  = glyph.code;
            last_nxt = 1'b1;
            if (glyph.found) begin
              state_nxt = ST_SEND;
            end
          end else begin
            neg_nxt = raw[VALUE_W-1];
            mag_nxt = raw[VALUE_W-1] ? VALUE_W'(0) - raw : raw;
            pos_nxt = '0;
            if (raw != '0) begin
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        sel_nxt   = select_for(pos_r);
        seg_nxt   = digit_seg;
        last_nxt  = (pos_r == LAST_POS) || ((quotient == '0) && !neg_r);
        mag_nxt   = quotient;
        pos_nxt   = pos_r + POS_W'(1);
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_ch.ready) begin
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else if (mag_r != '0) begin
            state_nxt = ST_MUL;
          end else begin
            sel_nxt  = select_for(pos_r);
            seg_nxt  = MINUS_CODE;
            last_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = (state_r == ST_SEND);
  assign out_ch.digit_select = sel_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.last_frame   = last_r;

endmodule

// ===== rtl/ssd_div10.sv =====
// Shared divide-by-ten unit: reciprocal multiply with a registered product,
// then remainder by shift-add and subtract. Depends on ssd_pkg.
module ssd_div10 (
  input  logic                        clk,
  input  logic                        start,
  input  logic [ssd_pkg::VALUE_W-1:0] dividend,
  output logic [ssd_pkg::VALUE_W-1:0] quotient,
  output logic [3:0]                  remainder
);
  import ssd_pkg::*;

  logic [PROD_W-1:0]  prod_r;
  logic [VALUE_W-1:0] dividend_r;
  logic [VALUE_W-1:0] times_ten;
  logic [VALUE_W-1:0] diff;

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r     <= PROD_W'(dividend) * PROD_W'(RECIP_TEN);
      dividend_r <= dividend;
    end
  end

  assign quotient  = VALUE_W'(prod_r >> RECIP_SHIFT);
  assign times_ten = (quotient << 3) + (quotient << 1);
  assign diff      = dividend_r - times_ten;
  assign remainder = diff[3:0];

endmodule

// ===== rtl/ssd_checker.sv =====
// Port-level checks for the seven-segment frame builder and the bind that attaches them.
// Depends on ssd_pkg and on the top level's ports.
module ssd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ssd_pkg::SEL_W-1:0]   out_digit_select,
  input logic [ssd_pkg::SEG_W-1:0]   out_segments,
  input logic                        out_last_frame
);
  import ssd_pkg::*;

  a_frame_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_select)
      && $stable(out_segments) && $stable(out_last_frame))
    else $error("Stalled frame changed before its transfer.");

  a_select_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_digit_select))
    else $error("Digit select is not one-hot.");

  a_busy_while_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("Input accepted while a frame is pending.");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_frame |=> !out_valid && in_ready)
    else $error("Frames continue after the last frame transfer.");

endmodule

bind seven_segment_digit_frame_builder_top ssd_checker u_ssd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_digit_select (out_ch.digit_select),
  .out_segments     (out_ch.segments),
  .out_last_frame   (out_ch.last_frame)
);

// ===== bench/tb_seven_segment_digit_frame_builder_top.sv =====
// Self-checking testbench for seven_segment_digit_frame_builder_top.
// It predicts the display frames of every accepted item and compares them with the
// frames the block sends, with random gaps on both channels; depends on ssd_pkg and ssd_if.
module tb_seven_segment_digit_frame_builder_top;
  import ssd_pkg::*;

  localparam logic OP_NUMBER = 1'b0;
  localparam logic OP_CHAR   = 1'b1;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   PHASE_ITEMS   = 29;
  localparam int   MAX_PRINTS    = 40;

  localparam logic [7:0] SYM_ASCII [28] = '{
    "0", "1", "2", "3", "4", "5", "6", "7", "8", "9",
    "A", "B", "C", "D", "E", "F", "G", "H", "I", "J",
    "L", "O", "P", "S", "U", ".", " ", "-"
  };
  localparam logic [7:0] SYM_SEG [28] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90,
    8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'h82, 8'h89, 8'hF9, 8'hE1,
    8'hC7, 8'hC0, 8'h8C, 8'h92, 8'hC1, 8'h7F, 8'hFF, 8'hBF
  };
  localparam logic [7:0] MINUS_SEG = 8'hBF;

  typedef struct {
    logic        op;
    logic [31:0] value;
  } show_req_t;

  typedef struct {
    logic [7:0] digit_select;
    logic [7:0] segments;
    logic       last_frame;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [SEG_W-1:0] cfg_wdata;

  ssd_in_if  in_if ();
  ssd_out_if out_if ();

  seven_segment_digit_frame_builder_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  show_req_t  request_q[$];
  frame_t     frame_expect_q[$];
  logic [7:0] dot_model;
  logic       steady_flow;
  logic       in_xfer;
  int         in_gap;
  int         out_gap;
  int         err_count;
  int         items_sent;
  int         frames_checked;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic void predict_frames(input show_req_t req);
    frame_t      burst[$];
    frame_t      f;
    logic [31:0] mag;
    int          pos;
    f.last_frame = 1'b0;
    if (req.op == OP_CHAR) begin
      for (int i = 0; i < 28; i++) begin
        if (SYM_ASCII[i] == req.value[7:0]) begin
          f.digit_select = 8'(1) << (DIGIT_COUNT - 1);
          f.segments     = SYM_SEG[i];
          burst.push_back(f);
          break;
        end
      end
    end else begin
      mag = req.value[31] ? (~req.value + 32'd1) : req.value;
      pos = 0;
      while (mag != 0 && pos < DIGIT_COUNT) begin
        f.digit_select = 8'(1) << (DIGIT_COUNT - 1 - pos);
        f.segments     = SYM_SEG[mag % 10];
        if (dot_model[pos]) f.segments[7] = 1'b0;
        burst.push_back(f);
        mag = mag / 10;
        pos++;
      end
      if (req.value[31] && pos < DIGIT_COUNT) begin
        f.digit_select = 8'(1) << (DIGIT_COUNT - 1 - pos);
        f.segments     = MINUS_SEG;
        burst.push_back(f);
      end
    end
    if (burst.size() > 0) burst[burst.size() - 1].last_frame = 1'b1;
    foreach (burst[i]) frame_expect_q.push_back(burst[i]);
  endfunction

  always @(negedge clk) begin
    show_req_t req;
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.operation <= OP_NUMBER;
      in_if.value     <= '0;
      in_gap          <= 0;
    end else if (in_if.valid && !in_xfer) begin
    end else if (in_gap > 0) begin
      in_gap      <= in_gap - 1;
      in_if.valid <= 1'b0;
    end else if (request_q.size() > 0) begin
      req = request_q.pop_front();
      in_if.valid     <= 1'b1;
      in_if.operation <= req.op;
      in_if.value     <= req.value;
      in_gap          <= gap_len();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    int g;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap      <= 0;
    end else if (out_gap > 0) begin
      out_gap      <= out_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
      out_if.ready <= (g == 0);
      out_gap      <= (g == 0) ? 0 : g - 1;
    end
  end

  always @(posedge clk) begin
    show_req_t req;
    frame_t    want;
    in_xfer <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      req.op    = in_if.operation;
      req.value = in_if.value;
      predict_frames(req);
      items_sent++;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (frame_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected frame sel=%h seg=%h last=%b",
                                  out_if.digit_select, out_if.segments, out_if.last_frame));
      end else begin
        want = frame_expect_q.pop_front();
        frames_checked++;
        if (out_if.digit_select !== want.digit_select)
          report_mismatch($sformatf("digit_select got %h want %h",
                                    out_if.digit_select, want.digit_select));
        if (out_if.segments !== want.segments)
          report_mismatch($sformatf("segments got %h want %h",
                                    out_if.segments, want.segments));
        if (out_if.last_frame !== want.last_frame)
          report_mismatch($sformatf("last_frame got %b want %b",
                                    out_if.last_frame, want.last_frame));
      end
    end
  end

  task automatic wait_idle();
    do @(posedge clk); while (request_q.size() != 0 || in_if.valid || frame_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_dot_mask(input logic [7:0] mask);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mask;
    @(posedge clk);
    dot_model = mask;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_request(input logic op, input logic [31:0] value);
    show_req_t req;
    req.op    = op;
    req.value = value;
    request_q.push_back(req);
  endtask

  task automatic add_random_requests(input int count);
    int          r;
    int          ndig;
    logic [31:0] mag;
    logic [31:0] raw;
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(0, 99);
      raw = $urandom();
      if (r < 25) begin
        if ($urandom_range(0, 4) != 0) raw[7:0] = SYM_ASCII[$urandom_range(0, 27)];
        if ($urandom_range(0, 1) == 0) raw[31:8] = '0;
        add_request(OP_CHAR, raw);
      end else if (r < 28) begin
        add_request(OP_NUMBER, 32'd0);
      end else if (r < 38) begin
        add_request(OP_NUMBER, raw);
      end else begin
        ndig = $urandom_range(1, 10);
        if (ndig == 10) mag = $urandom_range(32'd1000000000, 32'd2147483647);
        else if (ndig == 1) mag = $urandom_range(1, 9);
        else mag = $urandom_range(10 ** (ndig - 1), 10 ** ndig - 1);
        add_request(OP_NUMBER, $urandom_range(0, 1) ? -mag : mag);
      end
    end
  endtask

  initial begin
    logic [7:0] masks [5];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.operation = OP_NUMBER;
    in_if.value     = '0;
    out_if.ready    = 1'b0;
    in_xfer         = 1'b0;
    in_gap          = 0;
    out_gap         = 0;
    dot_model       = '0;
    steady_flow     = 1'b0;
    err_count       = 0;
    items_sent      = 0;
    frames_checked  = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items run with the dot mask still at its reset value.
    add_request(OP_NUMBER, 32'd0);
    add_request(OP_NUMBER, 32'd1);
    add_request(OP_NUMBER, 32'hFFFF_FFFF);
    add_request(OP_NUMBER, 32'd9);
    add_request(OP_NUMBER, 32'd10);
    add_request(OP_NUMBER, 32'd12345678);
    add_request(OP_NUMBER, -32'sd12345678);
    add_request(OP_NUMBER, -32'sd1234567);
    add_request(OP_NUMBER, 32'd100000000);
    add_request(OP_NUMBER, 32'h7FFF_FFFF);
    add_request(OP_NUMBER, 32'h8000_0001);
    add_request(OP_NUMBER, 32'h8000_0000);
    add_request(OP_CHAR, "0");
    add_request(OP_CHAR, "9");
    add_request(OP_CHAR, "A");
    add_request(OP_CHAR, "U");
    add_request(OP_CHAR, ".");
    add_request(OP_CHAR, " ");
    add_request(OP_CHAR, "-");
    add_request(OP_CHAR, "K");
    add_request(OP_CHAR, 32'h0000_0000);
    add_request(OP_CHAR, 32'h0000_00FF);
    add_request(OP_CHAR, 32'h0000_0130);
    add_request(OP_CHAR, 32'hFFFF_FF41);
    add_request(OP_CHAR, 32'h8000_0061);

    masks = '{8'hFF, 8'h00, 8'hA5, 8'h00, 8'h81};
    masks[3] = 8'($urandom());
    foreach (masks[p]) begin
      wait_idle();
      steady_flow = (p == 2);
      write_dot_mask(masks[p]);
      add_random_requests(PHASE_ITEMS);
    end
    wait_idle();

    $display("Run covered %0d items in number and character mode and %0d frames,",
             items_sent, frames_checked);
    $display("across six dot mask settings with random stalls on both channels.");
    if (err_count == 0) begin
      $display("tb_seven_segment_digit_frame_builder_top passed");
    end else begin
      $display("tb_seven_segment_digit_frame_builder_top failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d frames still expected.", frame_expect_q.size());
    $display("tb_seven_segment_digit_frame_builder_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ssd_pkg.sv
rtl/ssd_if.sv
rtl/ssd_div10.sv
rtl/seven_segment_digit_frame_builder_top.sv
rtl/ssd_checker.sv
bench/tb_seven_segment_digit_frame_builder_top.sv
